// ===== rtl/ptef_pkg.sv =====
// Package for the pan/tilt error follow controller.
// Holds shared widths, constants, register indexes, state codes and types.
// No dependencies.
`timescale 1ns / 1ps

package ptef_pkg;

   localparam int ANGLE_W    = 17;
   localparam int ERR_W      = 16;
   localparam int TIME_W     = 32;
   localparam int BAND_W     = 15;
   localparam int GAIN_W     = 16;
   localparam int MUL_W      = 16;
   localparam int PROD_W     = 2 * MUL_W;
   localparam int DT_W       = 8;
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 17;
   localparam int HOME_NUM_W = 24;
   localparam int HOME_DIV_W = 10;
   localparam int TRK_W      = 2;

   // Angle range in 1/256 degree
   localparam logic signed [ANGLE_W-1:0] ANGLE_CAP   = 17'sd46080;
   localparam logic signed [ANGLE_W-1:0] ANGLE_FLOOR = -17'sd46080;

   // Frame interval limits in ms
   localparam logic [DT_W-1:0] DT_FIRST = 8'd33;
   localparam logic [DT_W-1:0] DT_MIN   = 8'd20;
   localparam logic [DT_W-1:0] DT_MAX   = 8'd200;

   // Rounding terms for the two scale steps and the homing step
   localparam logic [PROD_W-1:0]     GAIN_ROUND   = 32'd16384;
   localparam logic [PROD_W-1:0]     ALPHA_ROUND  = 32'd128;
   localparam logic [HOME_NUM_W-1:0] HOME_BIAS    = 24'd500;
   localparam logic [HOME_DIV_W-1:0] HOME_DIVISOR = 10'd1000;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ERR_BAND_X  = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ERR_BAND_Y  = 4'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_YAW_GAIN    = 4'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PITCH_GAIN  = 4'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_YAW_LIMIT   = 4'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_PITCH_LOW   = 4'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_PITCH_HIGH  = 4'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_LOST_TMO    = 4'd7;

   // Track state codes on the result channel
   localparam logic [TRK_W-1:0] TRK_TRACKING = 2'd0;
   localparam logic [TRK_W-1:0] TRK_LOST     = 2'd1;
   localparam logic [TRK_W-1:0] TRK_HOMING   = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_EVAL,
      ST_MUL_GAIN,
      ST_SCALE,
      ST_MUL_ALPHA,
      ST_APPLY,
      ST_HOME_MUL,
      ST_HOME_DIV,
      ST_HOME,
      ST_DONE
   } seq_state_type;

   // Configuration as seen by the datapath, limits already saturated
   typedef struct packed {
      logic [BAND_W-1:0]         err_band_x;
      logic [BAND_W-1:0]         err_band_y;
      logic [GAIN_W-1:0]         yaw_gain;
      logic [GAIN_W-1:0]         pitch_gain;
      logic [ANGLE_W-1:0]        yaw_lim;
      logic signed [ANGLE_W-1:0] pitch_lo;
      logic signed [ANGLE_W-1:0] pitch_hi;
      logic [15:0]               lost_timeout;
   } cfg_type;

endpackage

// ===== rtl/ptef_csr.sv =====
// Configuration registers of the pan/tilt controller.
// Depends on ptef_pkg; saturates the angle limits for the datapath.
`timescale 1ns / 1ps

module ptef_csr
   import ptef_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output cfg_type               cfg
);

   logic [BAND_W-1:0]         err_band_x_ff, err_band_y_ff;
   logic [GAIN_W-1:0]         yaw_gain_ff, pitch_gain_ff;
   logic [15:0]               yaw_limit_ff, lost_tmo_ff;
   logic signed [ANGLE_W-1:0] pitch_low_ff, pitch_high_ff;
   logic [ANGLE_W-1:0]        yaw_limit_ext;

   always_ff @(posedge clock) begin
      if (reset) begin
         err_band_x_ff  <= 15'd1638;
         err_band_y_ff  <= 15'd1638;
         yaw_gain_ff    <= 16'd2560;
         pitch_gain_ff  <= 16'd2560;
         yaw_limit_ff   <= 16'd15360;
         pitch_low_ff   <= -17'sd7680;
         pitch_high_ff  <= 17'sd7680;
         lost_tmo_ff    <= 16'd2000;
      end else if (csr_we) begin
         case (csr_index)
            CSR_ERR_BAND_X:  err_band_x_ff  <= csr_wdata[BAND_W-1:0];
            CSR_ERR_BAND_Y:  err_band_y_ff  <= csr_wdata[BAND_W-1:0];
            CSR_YAW_GAIN:    yaw_gain_ff    <= csr_wdata[GAIN_W-1:0];
            CSR_PITCH_GAIN:  pitch_gain_ff  <= csr_wdata[GAIN_W-1:0];
            CSR_YAW_LIMIT:   yaw_limit_ff   <= csr_wdata[15:0];
            CSR_PITCH_LOW:   pitch_low_ff   <= $signed(csr_wdata);
            CSR_PITCH_HIGH:  pitch_high_ff  <= $signed(csr_wdata);
            CSR_LOST_TMO:    lost_tmo_ff    <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   assign yaw_limit_ext = {1'b0, yaw_limit_ff};

   always_comb begin
      cfg.err_band_x   = err_band_x_ff;
      cfg.err_band_y   = err_band_y_ff;
      cfg.yaw_gain     = yaw_gain_ff;
      cfg.pitch_gain   = pitch_gain_ff;
      cfg.lost_timeout = lost_tmo_ff;
      cfg.yaw_lim      = (yaw_limit_ext > ANGLE_CAP) ? ANGLE_CAP : yaw_limit_ext;
      cfg.pitch_lo     = (pitch_low_ff < ANGLE_FLOOR) ? ANGLE_FLOOR :
                         (pitch_low_ff > ANGLE_CAP) ? ANGLE_CAP : pitch_low_ff;
      cfg.pitch_hi     = (pitch_high_ff < ANGLE_FLOOR) ? ANGLE_FLOOR :
                         (pitch_high_ff > ANGLE_CAP) ? ANGLE_CAP : pitch_high_ff;
   end

endmodule

// ===== rtl/ptef_smul.sv =====
// Bit-serial unsigned multiplier, one multiplier bit per cycle.
// Depends on ptef_pkg for operand widths.
`timescale 1ns / 1ps

module ptef_smul
   import ptef_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [MUL_W-1:0]  a,
   input  logic [MUL_W-1:0]  b,
   output logic              busy,
   output logic [PROD_W-1:0] prod
);

   localparam int CNT_W = $clog2(MUL_W);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MUL_W - 1);

   logic              busy_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic [MUL_W-1:0]  a_ff;
   logic [PROD_W-1:0] prod_ff, prod_in;
   logic [MUL_W:0]    partial;

   // Add the multiplicand into the upper half, then shift right one bit
   assign partial = {1'b0, prod_ff[PROD_W-1:MUL_W]} + (prod_ff[0] ? {1'b0, a_ff} : '0);
   assign prod_in = {partial, prod_ff[MUL_W-1:1]};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= '0;
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff + 1'b1;
         if (cnt_ff == CNT_LAST) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         a_ff    <= a;
         prod_ff <= {{MUL_W{1'b0}}, b};
      end else if (busy_ff) begin
         prod_ff <= prod_in;
      end
   end

   assign busy = busy_ff;
   assign prod = prod_ff;

endmodule

// ===== rtl/ptef_cdiv.sv =====
// Bit-serial restoring divider by the fixed homing divisor.
// Depends on ptef_pkg for the divisor and numerator width.
`timescale 1ns / 1ps

module ptef_cdiv
   import ptef_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [HOME_NUM_W-1:0] num,
   output logic                  busy,
   output logic [HOME_NUM_W-1:0] quo
);

   localparam int CNT_W = $clog2(HOME_NUM_W);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(HOME_NUM_W - 1);

   logic                  busy_ff;
   logic [CNT_W-1:0]      cnt_ff;
   logic [HOME_NUM_W-1:0] q_ff;
   logic [HOME_DIV_W-1:0] rem_ff, rem_in;
   logic [HOME_DIV_W:0]   trial, trial_sub;
   logic                  fits;

   // Bring down the next numerator bit, subtract the divisor if it fits
   assign trial     = {rem_ff, q_ff[HOME_NUM_W-1]};
   assign fits      = trial >= {1'b0, HOME_DIVISOR};
   assign trial_sub = trial - {1'b0, HOME_DIVISOR};
   assign rem_in    = fits ? trial_sub[HOME_DIV_W-1:0] : trial[HOME_DIV_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= '0;
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff + 1'b1;
         if (cnt_ff == CNT_LAST) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         q_ff   <= num;
         rem_ff <= '0;
      end else if (busy_ff) begin
         q_ff   <= {q_ff[HOME_NUM_W-2:0], fits};
         rem_ff <= rem_in;
      end
   end

   assign busy = busy_ff;
   assign quo  = q_ff;

endmodule

// ===== rtl/pan_tilt_error_follow_controller_top.sv =====
// Top level of the pan/tilt error follow controller.
// Depends on ptef_pkg, ptef_csr, ptef_smul and ptef_cdiv.
//
// One input transfer is one camera frame result; one output transfer is the
// resulting yaw/pitch command, track state and lost time. On a hit the x and
// y errors pass a dead band, are scaled by their gains (yaw negated), clamped
// to the maximum step, smoothed by SMOOTH_ALPHA/256 and added to the current
// angles, which are then clamped to the configured limits. On a miss the lost
// time is reported, and once it exceeds lost_timeout_ms both angles move
// toward zero by HOME_RATE * frame interval / 1000 (interval clamped to
// 20..200 ms, 33 ms on the first frame). Angles are signed 1/256 degree.
// One frame is worked at a time. A hit makes two passes through the
// bit-serial multipliers (yaw and pitch have one each and run side by side).
// A homing miss takes one multiply plus the serial divider. A miss before
// the timeout uses neither. The input accepts the next frame as soon as the
// previous result sits in the output register, even if that result is still
// stalled. Write configuration only while no frame is in flight.
`timescale 1ns / 1ps

module pan_tilt_error_follow_controller_top
   import ptef_pkg::*;
#(
   parameter int unsigned MAX_STEP_YAW   = 1280,
   parameter int unsigned MAX_STEP_PITCH = 1280,
   parameter int unsigned SMOOTH_ALPHA   = 77,
   parameter int unsigned HOME_RATE      = 7680
)(
   input  logic                      clock,
   input  logic                      reset,
   // frame input
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic                      req_target_found,
   input  logic signed [ERR_W-1:0]   req_error_x,
   input  logic signed [ERR_W-1:0]   req_error_y,
   input  logic [TIME_W-1:0]         req_time_ms,
   // command output
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic signed [ANGLE_W-1:0] rsp_yaw_angle,
   output logic signed [ANGLE_W-1:0] rsp_pitch_angle,
   output logic [TRK_W-1:0]          rsp_track_state,
   output logic [TIME_W-1:0]         rsp_lost_time_ms,
   // configuration
   input  logic                      csr_we,
   input  logic [CSR_IDX_W-1:0]      csr_index,
   input  logic [CSR_DATA_W-1:0]     csr_wdata
);

   localparam logic [MUL_W-1:0] MAX_YAW   = MUL_W'(MAX_STEP_YAW);
   localparam logic [MUL_W-1:0] MAX_PITCH = MUL_W'(MAX_STEP_PITCH);
   localparam logic [MUL_W-1:0] ALPHA     = MUL_W'(SMOOTH_ALPHA);
   localparam logic [MUL_W-1:0] HRATE     = MUL_W'(HOME_RATE);

   // Move one angle toward zero by step without overshoot; snap tiny values
   function automatic logic signed [ANGLE_W-1:0] home_axis(
      input logic signed [ANGLE_W-1:0] pos,
      input logic [MUL_W-1:0]          step
   );
      logic [ANGLE_W:0] mag;
      logic [ANGLE_W:0] lim;
      logic signed [ANGLE_W+1:0] res;
      begin
         mag = pos[ANGLE_W-1] ? (ANGLE_W+1)'(-{pos[ANGLE_W-1], pos})
                              : {1'b0, pos};
         lim = ({2'b0, step} > mag) ? mag : {2'b0, step};
         if (mag <= 18'd1) begin
            res = '0;
         end else if (pos[ANGLE_W-1]) begin
            res = {{2{pos[ANGLE_W-1]}}, pos} + $signed({1'b0, lim});
         end else begin
            res = {{2{pos[ANGLE_W-1]}}, pos} - $signed({1'b0, lim});
         end
         home_axis = res[ANGLE_W-1:0];
      end
   endfunction

   cfg_type cfg;

   ptef_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // ---------------------------------------------------------------------
   // Serial arithmetic units: lane 0 serves yaw and homing, lane 1 pitch
   // ---------------------------------------------------------------------
   logic              mul0_start, mul1_start, div_start;
   logic [MUL_W-1:0]  mul0_a, mul0_b, mul1_a, mul1_b;
   logic              mul0_busy, mul1_busy, div_busy;
   logic [PROD_W-1:0] mul0_prod, mul1_prod;
   logic [HOME_NUM_W-1:0] div_num, div_quo;

   ptef_smul u_mul_yaw (
      .clock (clock), .reset (reset), .start (mul0_start),
      .a (mul0_a), .b (mul0_b), .busy (mul0_busy), .prod (mul0_prod)
   );

   ptef_smul u_mul_pitch (
      .clock (clock), .reset (reset), .start (mul1_start),
      .a (mul1_a), .b (mul1_b), .busy (mul1_busy), .prod (mul1_prod)
   );

   ptef_cdiv u_div (
      .clock (clock), .reset (reset), .start (div_start),
      .num (div_num), .busy (div_busy), .quo (div_quo)
   );

   // ---------------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------------
   seq_state_type state_ff, state_in;

   logic signed [ANGLE_W-1:0] yaw_pos_ff, pitch_pos_ff;
   logic [TIME_W-1:0]         last_hit_ff, last_frame_ff;
   logic                      frame_seen_ff;

   logic                    found_ff;
   logic signed [ERR_W-1:0] err_x_ff, err_y_ff;
   logic [DT_W-1:0]         dt_ff;
   logic [TIME_W-1:0]       lost_ff;
   logic [TRK_W-1:0]        track_ff;
   logic                    yaw_neg_ff, pitch_neg_ff;

   logic                      rsp_valid_ff;
   logic signed [ANGLE_W-1:0] rsp_yaw_ff, rsp_pitch_ff;
   logic [TRK_W-1:0]          rsp_track_ff;
   logic [TIME_W-1:0]         rsp_lost_ff;

   // ---------------------------------------------------------------------
   // Transfer-cycle arithmetic: frame interval and lost time
   // ---------------------------------------------------------------------
   logic              req_xfer;
   logic [TIME_W-1:0] frame_diff, lost_in;
   logic [DT_W-1:0]   dt_in;

   assign req_xfer   = req_valid && !req_stall;
   assign frame_diff = req_time_ms - last_frame_ff;
   assign lost_in    = req_time_ms - last_hit_ff;

   always_comb begin
      if (!frame_seen_ff) begin
         dt_in = DT_FIRST;
      end else if (frame_diff < {24'b0, DT_MIN}) begin
         dt_in = DT_MIN;
      end else if (frame_diff > {24'b0, DT_MAX}) begin
         dt_in = DT_MAX;
      end else begin
         dt_in = frame_diff[DT_W-1:0];
      end
   end

   // ---------------------------------------------------------------------
   // Evaluation: dead band and homing decision
   // ---------------------------------------------------------------------
   logic [ERR_W-1:0] mag_x, mag_y, band_x, band_y;
   logic             home_go;

   assign mag_x   = err_x_ff[ERR_W-1] ? (~err_x_ff + 1'b1) : err_x_ff;
   assign mag_y   = err_y_ff[ERR_W-1] ? (~err_y_ff + 1'b1) : err_y_ff;
   assign band_x  = (mag_x < {1'b0, cfg.err_band_x}) ? '0 : mag_x;
   assign band_y  = (mag_y < {1'b0, cfg.err_band_y}) ? '0 : mag_y;
   assign home_go = lost_ff > {16'b0, cfg.lost_timeout};

   // ---------------------------------------------------------------------
   // Scale: round gain product, clamp to max step
   // ---------------------------------------------------------------------
   logic [PROD_W-1:0] gain_sum_y, gain_sum_p;
   logic [MUL_W:0]    gain_rnd_y, gain_rnd_p;
   logic [MUL_W-1:0]  step_y, step_p;

   assign gain_sum_y = mul0_prod + GAIN_ROUND;
   assign gain_sum_p = mul1_prod + GAIN_ROUND;
   assign gain_rnd_y = gain_sum_y[PROD_W-1:15];
   assign gain_rnd_p = gain_sum_p[PROD_W-1:15];
   assign step_y = (gain_rnd_y > {1'b0, MAX_YAW}) ? MAX_YAW : gain_rnd_y[MUL_W-1:0];
   assign step_p = (gain_rnd_p > {1'b0, MAX_PITCH}) ? MAX_PITCH : gain_rnd_p[MUL_W-1:0];

   // ---------------------------------------------------------------------
   // Apply: round smoothed step, add to angle, clamp to limits
   // ---------------------------------------------------------------------
   logic [PROD_W-1:0]         alpha_sum_y, alpha_sum_p;
   logic [MUL_W-1:0]          smooth_y, smooth_p;
   logic signed [ANGLE_W+1:0] delta_y, delta_p, sum_y, sum_p;
   logic signed [ANGLE_W+1:0] ylim_hi, ylim_lo, plim_lo, plim_hi, raise_p;
   logic signed [ANGLE_W+1:0] yaw_new, pitch_new;

   assign alpha_sum_y = mul0_prod + ALPHA_ROUND;
   assign alpha_sum_p = mul1_prod + ALPHA_ROUND;
   assign smooth_y    = alpha_sum_y[MUL_W+7:8];
   assign smooth_p    = alpha_sum_p[MUL_W+7:8];

   assign delta_y = yaw_neg_ff   ? -$signed({3'b0, smooth_y}) : $signed({3'b0, smooth_y});
   assign delta_p = pitch_neg_ff ? -$signed({3'b0, smooth_p}) : $signed({3'b0, smooth_p});
   assign sum_y   = {{2{yaw_pos_ff[ANGLE_W-1]}}, yaw_pos_ff} + delta_y;
   assign sum_p   = {{2{pitch_pos_ff[ANGLE_W-1]}}, pitch_pos_ff} + delta_p;

   assign ylim_hi = $signed({2'b0, cfg.yaw_lim});
   assign ylim_lo = -ylim_hi;
   assign plim_lo = {{2{cfg.pitch_lo[ANGLE_W-1]}}, cfg.pitch_lo};
   assign plim_hi = {{2{cfg.pitch_hi[ANGLE_W-1]}}, cfg.pitch_hi};

   assign yaw_new   = (sum_y > ylim_hi) ? ylim_hi : ((sum_y < ylim_lo) ? ylim_lo : sum_y);
   // Raise to the low limit first, then lower to the high one: high wins
   assign raise_p   = (sum_p < plim_lo) ? plim_lo : sum_p;
   assign pitch_new = (raise_p > plim_hi) ? plim_hi : raise_p;

   // ---------------------------------------------------------------------
   // Sequencer: next state
   // ---------------------------------------------------------------------
   logic rsp_load;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            if (found_ff) begin
               state_in = ST_MUL_GAIN;
            end else if (home_go) begin
               state_in = ST_HOME_MUL;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_MUL_GAIN: begin
            if (!mul0_busy && !mul1_busy) begin
               state_in = ST_SCALE;
            end
         end
         ST_SCALE: state_in = ST_MUL_ALPHA;
         ST_MUL_ALPHA: begin
            if (!mul0_busy && !mul1_busy) begin
               state_in = ST_APPLY;
            end
         end
         ST_APPLY: state_in = ST_DONE;
         ST_HOME_MUL: begin
            if (!mul0_busy) begin
               state_in = ST_HOME_DIV;
            end
         end
         ST_HOME_DIV: begin
            if (!div_busy) begin
               state_in = ST_HOME;
            end
         end
         ST_HOME: state_in = ST_DONE;
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // ---------------------------------------------------------------------
   // Sequencer: outputs and unit operands
   // ---------------------------------------------------------------------
   always_comb begin
      req_stall  = 1'b1;
      mul0_start = 1'b0;
      mul1_start = 1'b0;
      div_start  = 1'b0;
      mul0_a     = band_x;
      mul0_b     = cfg.yaw_gain;
      mul1_a     = band_y;
      mul1_b     = cfg.pitch_gain;
      div_num    = mul0_prod[HOME_NUM_W-1:0] + HOME_BIAS;
      rsp_load   = 1'b0;
      case (state_ff)
         ST_IDLE: req_stall = 1'b0;
         ST_EVAL: begin
            if (found_ff) begin
               mul0_start = 1'b1;
               mul1_start = 1'b1;
            end else if (home_go) begin
               mul0_start = 1'b1;
               mul0_a     = HRATE;
               mul0_b     = {{(MUL_W-DT_W){1'b0}}, dt_ff};
            end
         end
         ST_SCALE: begin
            mul0_start = 1'b1;
            mul1_start = 1'b1;
            mul0_a     = step_y;
            mul0_b     = ALPHA;
            mul1_a     = step_p;
            mul1_b     = ALPHA;
         end
         ST_HOME_MUL: div_start = !mul0_busy;
         ST_DONE:     rsp_load  = !rsp_valid_ff || !rsp_stall;
         default: ;
      endcase
   end

   // ---------------------------------------------------------------------
   // Control state and persistent tracker state
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         yaw_pos_ff    <= '0;
         pitch_pos_ff  <= '0;
         last_hit_ff   <= '0;
         last_frame_ff <= '0;
         frame_seen_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (req_xfer) begin
            last_frame_ff <= req_time_ms;
            frame_seen_ff <= 1'b1;
            if (req_target_found) begin
               last_hit_ff <= req_time_ms;
            end
         end
         if (state_ff == ST_APPLY) begin
            yaw_pos_ff   <= yaw_new[ANGLE_W-1:0];
            pitch_pos_ff <= pitch_new[ANGLE_W-1:0];
         end else if (state_ff == ST_HOME) begin
            yaw_pos_ff   <= home_axis(yaw_pos_ff, div_quo[MUL_W-1:0]);
            pitch_pos_ff <= home_axis(pitch_pos_ff, div_quo[MUL_W-1:0]);
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Frame payload and result register
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         found_ff <= req_target_found;
         err_x_ff <= req_error_x;
         err_y_ff <= req_error_y;
         dt_ff    <= dt_in;
         lost_ff  <= lost_in;
      end
      if (state_ff == ST_EVAL) begin
         // Yaw moves against the horizontal error
         yaw_neg_ff   <= !err_x_ff[ERR_W-1];
         pitch_neg_ff <= err_y_ff[ERR_W-1];
         track_ff     <= found_ff ? TRK_TRACKING : (home_go ? TRK_HOMING : TRK_LOST);
      end
      if (rsp_load) begin
         rsp_yaw_ff   <= yaw_pos_ff;
         rsp_pitch_ff <= pitch_pos_ff;
         rsp_track_ff <= track_ff;
         rsp_lost_ff  <= found_ff ? '0 : lost_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_yaw_angle    = rsp_yaw_ff;
   assign rsp_pitch_angle  = rsp_pitch_ff;
   assign rsp_track_state  = rsp_track_ff;
   assign rsp_lost_time_ms = rsp_lost_ff;

endmodule

// ===== rtl/ptef_checker.sv =====
// Port-level checks for the pan/tilt controller, bound to the top level.
// Depends on ptef_pkg and pan_tilt_error_follow_controller_top.
`timescale 1ns / 1ps

module ptef_checker
   import ptef_pkg::*;
(
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_stall,
   input logic                      rsp_valid,
   input logic                      rsp_stall,
   input logic signed [ANGLE_W-1:0] rsp_yaw_angle,
   input logic signed [ANGLE_W-1:0] rsp_pitch_angle,
   input logic [TRK_W-1:0]          rsp_track_state,
   input logic [TIME_W-1:0]         rsp_lost_time_ms
);

   // A stalled result holds its transfer
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_yaw_angle)
         && $stable(rsp_pitch_angle) && $stable(rsp_lost_time_ms))
      else $error("stalled result changed");

   // One frame at a time: the input closes right after a transfer
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input open right after a transfer");

   // Tracking reports no lost time
   a_tracking_lost: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_track_state == TRK_TRACKING |-> rsp_lost_time_ms == '0)
      else $error("lost time nonzero while tracking");

   // Angles never leave the mechanical range
   a_angle_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_yaw_angle <= ANGLE_CAP && rsp_yaw_angle >= ANGLE_FLOOR
         && rsp_pitch_angle <= ANGLE_CAP && rsp_pitch_angle >= ANGLE_FLOOR)
      else $error("angle out of range");

   // Reset drops any pending result
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind pan_tilt_error_follow_controller_top ptef_checker u_ptef_checker (.*);

// ===== test/tb_pan_tilt_error_follow_controller_top.sv =====
// Self-checking testbench for the pan/tilt error follow controller top level.
// Predicts every command from its own copy of the tracker state and config.
// Depends on ptef_pkg and pan_tilt_error_follow_controller_top.
`timescale 1ns / 1ps

module tb_pan_tilt_error_follow_controller_top;
   import ptef_pkg::*;

   // Block parameters, kept at their defaults in the instance below
   localparam longint YAW_STEP_MAX   = 1280;
   localparam longint PITCH_STEP_MAX = 1280;
   localparam longint EMA_ALPHA      = 77;
   localparam longint HOME_DEG_RATE  = 7680;

   localparam longint ANGLE_LIMIT   = ANGLE_CAP;
   localparam int     CYCLE_LIMIT   = 1000000;
   localparam int     DRAIN_CYCLES  = 64;
   localparam int     PHASE_FRAMES  = 140;
   localparam int     PRINT_LIMIT   = 100;

   localparam logic [ERR_W-1:0]     ERR_MAX       = 16'h7FFF;
   localparam logic [ERR_W-1:0]     ERR_MIN       = 16'h8000;
   localparam logic [CSR_IDX_W-1:0] CSR_INDEX_TOP = {CSR_IDX_W{1'b1}};

   typedef struct packed {
      logic              found;
      logic [ERR_W-1:0]  err_x;
      logic [ERR_W-1:0]  err_y;
      logic [TIME_W-1:0] stamp;
   } frame_type;

   typedef struct packed {
      logic [ANGLE_W-1:0] yaw;
      logic [ANGLE_W-1:0] pitch;
      logic [TRK_W-1:0]   track;
      logic [TIME_W-1:0]  lost;
   } cmd_type;

   logic                      clock;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic                      req_target_found = 1'b0;
   logic signed [ERR_W-1:0]   req_error_x = '0;
   logic signed [ERR_W-1:0]   req_error_y = '0;
   logic [TIME_W-1:0]         req_time_ms = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic signed [ANGLE_W-1:0] rsp_yaw_angle;
   logic signed [ANGLE_W-1:0] rsp_pitch_angle;
   logic [TRK_W-1:0]          rsp_track_state;
   logic [TIME_W-1:0]         rsp_lost_time_ms;
   logic                      csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]      csr_index = CSR_ERR_BAND_X;
   logic [CSR_DATA_W-1:0]     csr_wdata = '0;

   pan_tilt_error_follow_controller_top u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_target_found (req_target_found),
      .req_error_x      (req_error_x),
      .req_error_y      (req_error_y),
      .req_time_ms      (req_time_ms),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_yaw_angle    (rsp_yaw_angle),
      .rsp_pitch_angle  (rsp_pitch_angle),
      .rsp_track_state  (rsp_track_state),
      .rsp_lost_time_ms (rsp_lost_time_ms),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Tracker mirror: config copy (reset values) and state
   // ---------------------------------------------------------------------
   longint band_x_cfg     = 1638;
   longint band_y_cfg     = 1638;
   longint yaw_gain_cfg   = 2560;
   longint pitch_gain_cfg = 2560;
   longint yaw_lim_cfg    = 15360;
   longint pitch_lo_cfg   = -7680;
   longint pitch_hi_cfg   = 7680;
   longint lost_tmo_cfg   = 2000;

   longint            yaw_pos       = 0;
   longint            pitch_pos     = 0;
   logic [TIME_W-1:0] last_hit_ms   = '0;
   logic [TIME_W-1:0] last_frame_ms = '0;
   bit                frame_seen    = 1'b0;

   frame_type frame_q[$];   // frames waiting to be driven
   cmd_type   cmd_q[$];     // commands predicted for accepted frames

   int               fail_count  = 0;
   int               cycle_count = 0;
   logic [TIME_W-1:0] stamp_ms   = '0;

   // round(v * mul / 2^sh), ties away from zero
   function automatic longint round_scale(input longint v, input longint mul, input int sh);
      longint mag;
      longint r;
      mag = (v < 0) ? -v : v;
      r   = (mag * mul + (longint'(1) <<< (sh - 1))) >>> sh;
      return (v < 0) ? -r : r;
   endfunction

   function automatic longint clip(input longint v, input longint lo, input longint hi);
      if (v < lo) v = lo;
      if (v > hi) v = hi;
      return v;
   endfunction

   // Move one angle toward zero; never cross it, snap tiny angles to zero
   function automatic longint home_toward_zero(input longint pos, input longint step);
      longint mag;
      mag = (pos < 0) ? -pos : pos;
      if (mag <= 1) return 0;
      if (step > mag) step = mag;
      return (pos < 0) ? pos + step : pos - step;
   endfunction

   // Advance the tracker mirror by one frame and return the command it gives
   function automatic cmd_type follow_frame(input frame_type f);
      cmd_type           c;
      logic [TIME_W-1:0] gap_ms;
      logic [TIME_W-1:0] dt_ms;
      logic [TIME_W-1:0] lost_ms;
      longint            ex, ey, ylim, plo, phi, dyaw, dpitch, v, step;
      dt_ms = TIME_W'(DT_FIRST);
      if (frame_seen) begin
         gap_ms = f.stamp - last_frame_ms;
         if (gap_ms < DT_MIN) dt_ms = TIME_W'(DT_MIN);
         else if (gap_ms > DT_MAX) dt_ms = TIME_W'(DT_MAX);
         else dt_ms = gap_ms;
      end
      last_frame_ms = f.stamp;
      frame_seen    = 1'b1;
      lost_ms       = '0;
      c.track       = TRK_TRACKING;
      if (f.found) begin
         ex   = $signed(f.err_x);
         ey   = $signed(f.err_y);
         ylim = clip(yaw_lim_cfg, 0, ANGLE_LIMIT);
         plo  = clip(pitch_lo_cfg, -ANGLE_LIMIT, ANGLE_LIMIT);
         phi  = clip(pitch_hi_cfg, -ANGLE_LIMIT, ANGLE_LIMIT);
         // strict dead band: an error equal to the band still counts
         if (((ex < 0) ? -ex : ex) < band_x_cfg) ex = 0;
         if (((ey < 0) ? -ey : ey) < band_y_cfg) ey = 0;
         dyaw   = clip(-round_scale(ex, yaw_gain_cfg, 15), -YAW_STEP_MAX, YAW_STEP_MAX);
         dpitch = clip(round_scale(ey, pitch_gain_cfg, 15), -PITCH_STEP_MAX, PITCH_STEP_MAX);
         v       = yaw_pos + round_scale(dyaw, EMA_ALPHA, 8);
         yaw_pos = clip(v, -ylim, ylim);
         // crossed limits: raise to the low one first, so the high one wins
         v = pitch_pos + round_scale(dpitch, EMA_ALPHA, 8);
         if (v < plo) v = plo;
         if (v > phi) v = phi;
         pitch_pos   = v;
         last_hit_ms = f.stamp;
      end else begin
         lost_ms = f.stamp - last_hit_ms;
         c.track = TRK_LOST;
         if (longint'(lost_ms) > lost_tmo_cfg) begin
            step      = (HOME_DEG_RATE * longint'(dt_ms) + 500) / 1000;
            c.track   = TRK_HOMING;
            yaw_pos   = home_toward_zero(yaw_pos, step);
            pitch_pos = home_toward_zero(pitch_pos, step);
         end
      end
      c.yaw   = yaw_pos[ANGLE_W-1:0];
      c.pitch = pitch_pos[ANGLE_W-1:0];
      c.lost  = lost_ms;
      return c;
   endfunction

   // ---------------------------------------------------------------------
   // Driver: present queued frames, pause a random number of cycles after
   // each transfer, with calm stretches that run back to back
   // ---------------------------------------------------------------------
   frame_type cur_frame;
   bit        presenting = 1'b0;
   int        feed_gap   = 0;
   int        feed_calm  = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         // predict at the transfer, while the config copy matches the block
         if (req_valid && !req_stall) begin
            cmd_q.push_back(follow_frame(cur_frame));
            presenting = 1'b0;
            if (feed_calm > 0) begin
               feed_calm--;
               feed_gap = 0;
            end else begin
               feed_gap = $urandom_range(0, 8);
               if ($urandom_range(0, 31) == 0) feed_calm = $urandom_range(10, 60);
            end
         end
         if (!presenting) begin
            if (feed_gap > 0) begin
               feed_gap--;
            end else if (frame_q.size() > 0) begin
               cur_frame = frame_q.pop_front();
               req_target_found <= cur_frame.found;
               req_error_x      <= cur_frame.err_x;
               req_error_y      <= cur_frame.err_y;
               req_time_ms      <= cur_frame.stamp;
               presenting = 1'b1;
            end
         end
         req_valid <= presenting;
      end
   end

   // ---------------------------------------------------------------------
   // Monitor: check each command transfer, then stall a random while
   // ---------------------------------------------------------------------
   cmd_type want;
   int      hold_left = 0;
   int      hold_calm = 0;

   task automatic check_field(input string what, input logic signed [63:0] want_v,
                              input logic signed [63:0] got_v);
      if (got_v !== want_v) begin
         fail_count++;
         if (fail_count <= PRINT_LIMIT)
            $display("%0t %s mismatch: expected %0d actual %0d", $time, what, want_v, got_v);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (cmd_q.size() == 0) begin
               fail_count++;
               if (fail_count <= PRINT_LIMIT)
                  $display("%0t command with no frame pending: expected none actual yaw %0d",
                           $time, rsp_yaw_angle);
            end else begin
               want = cmd_q.pop_front();
               check_field("yaw_angle", $signed(want.yaw), rsp_yaw_angle);
               check_field("pitch_angle", $signed(want.pitch), rsp_pitch_angle);
               check_field("track_state", want.track, rsp_track_state);
               check_field("lost_time_ms", want.lost, rsp_lost_time_ms);
            end
            if (hold_calm > 0) begin
               hold_calm--;
               hold_left = 0;
            end else begin
               hold_left = $urandom_range(0, 8);
               if ($urandom_range(0, 31) == 0) hold_calm = $urandom_range(10, 60);
            end
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Give up on a hung block
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------
   task automatic push_frame(input logic found, input logic [ERR_W-1:0] ex,
                             input logic [ERR_W-1:0] ey, input logic [TIME_W-1:0] stamp);
      frame_type f;
      f.found = found;
      f.err_x = ex;
      f.err_y = ey;
      f.stamp = stamp;
      frame_q.push_back(f);
   endtask

   // Hold until every queued frame has been transferred and answered
   task automatic drain_frames();
      while (frame_q.size() != 0 || presenting || cmd_q.size() != 0)
         @(posedge clock);
   endtask

   // Write one register and mirror it; the block samples it at the next edge
   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      case (idx)
         CSR_ERR_BAND_X:  band_x_cfg     = data[BAND_W-1:0];
         CSR_ERR_BAND_Y:  band_y_cfg     = data[BAND_W-1:0];
         CSR_YAW_GAIN:    yaw_gain_cfg   = data[GAIN_W-1:0];
         CSR_PITCH_GAIN:  pitch_gain_cfg = data[GAIN_W-1:0];
         CSR_YAW_LIMIT:   yaw_lim_cfg    = data[15:0];
         CSR_PITCH_LOW:   pitch_lo_cfg   = $signed(data);
         CSR_PITCH_HIGH:  pitch_hi_cfg   = $signed(data);
         CSR_LOST_TMO:    lost_tmo_cfg   = data[15:0];
         default: ;
      endcase
   endtask

   // Program every register, plus one write to an unused index that must
   // be dropped, then release the write enable
   task automatic program_setup(input logic [CSR_DATA_W-1:0] bx, by, yg, pg, yl, pl, ph, tmo);
      write_csr(CSR_ERR_BAND_X, bx);
      write_csr(CSR_ERR_BAND_Y, by);
      write_csr(CSR_YAW_GAIN, yg);
      write_csr(CSR_PITCH_GAIN, pg);
      write_csr(CSR_YAW_LIMIT, yl);
      write_csr(CSR_PITCH_LOW, pl);
      write_csr(CSR_PITCH_HIGH, ph);
      write_csr(CSR_INDEX_TOP - CSR_IDX_W'($urandom_range(0, CSR_INDEX_TOP - CSR_LOST_TMO - 1)),
                CSR_DATA_W'($urandom));
      write_csr(CSR_LOST_TMO, tmo);
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // Errors cluster on the dead band edges, the extremes and zero
   function automatic logic [ERR_W-1:0] pick_error(input longint band);
      int r;
      case ($urandom_range(0, 7))
         0: pick_error = ERR_W'($urandom);
         1: pick_error = ERR_W'(band);
         2: pick_error = ERR_W'(-band);
         3: pick_error = ERR_W'(band - 1);
         4: pick_error = $urandom_range(0, 1) ? ERR_MAX : ERR_MIN;
         5: pick_error = '0;
         default: begin
            r = $urandom_range(0, 2 * band + 100);
            pick_error = ERR_W'(r - band - 50);
         end
      endcase
   endfunction

   // Mostly frame-rate steps; sometimes short, long, backwards or anywhere
   task automatic advance_stamp();
      case ($urandom_range(0, 19))
         0: stamp_ms = stamp_ms - $urandom_range(1, 500);
         1: stamp_ms = stamp_ms + $urandom_range(0, 19);
         2: stamp_ms = stamp_ms + $urandom_range(201, 6000);
         3: stamp_ms = $urandom;
         default: stamp_ms = stamp_ms + $urandom_range(20, 80);
      endcase
   endtask

   // Random runs of hits and runs of misses; long miss runs reach homing
   task automatic track_random(input int count);
      int   left;
      int   run;
      logic hit;
      left = count;
      while (left > 0) begin
         hit = 1'($urandom_range(0, 1));
         run = hit ? $urandom_range(1, 15) : $urandom_range(1, 40);
         if (run > left) run = left;
         repeat (run) begin
            advance_stamp();
            push_frame(hit, pick_error(band_x_cfg), pick_error(band_y_cfg), stamp_ms);
            left--;
         end
      end
   endtask

   task automatic random_setup(input bit raw);
      if (raw)
         program_setup(CSR_DATA_W'($urandom), CSR_DATA_W'($urandom),
                       CSR_DATA_W'($urandom), CSR_DATA_W'($urandom),
                       CSR_DATA_W'($urandom), CSR_DATA_W'($urandom),
                       CSR_DATA_W'($urandom), CSR_DATA_W'($urandom));
      else
         program_setup(CSR_DATA_W'($urandom_range(0, 6000)),
                       CSR_DATA_W'($urandom_range(0, 6000)),
                       CSR_DATA_W'($urandom_range(0, 65535)),
                       CSR_DATA_W'($urandom_range(0, 65535)),
                       CSR_DATA_W'($urandom_range(0, 65535)),
                       CSR_DATA_W'(-$urandom_range(0, 50000)),
                       CSR_DATA_W'($urandom_range(0, 50000)),
                       CSR_DATA_W'($urandom_range(0, 2500)));
   endtask

   // ---------------------------------------------------------------------
   // Test sequence
   // ---------------------------------------------------------------------
   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed frames at the reset config
      push_frame(1'b0, '0, '0, 32'd5000);          // first frame, miss, homes from zero
      push_frame(1'b1, ERR_MAX, ERR_MIN, 32'd5033);
      push_frame(1'b1, ERR_MIN, ERR_MAX, 32'd5066);
      push_frame(1'b1, 16'd1638, -16'sd1638, 32'd5100);  // on the band edge
      push_frame(1'b1, 16'd1637, -16'sd1637, 32'd5133);  // just inside the band
      push_frame(1'b1, ERR_MAX, ERR_MAX, 32'd5140);
      push_frame(1'b0, ERR_MAX, ERR_MIN, 32'd6000);      // lost, errors ignored
      push_frame(1'b0, '0, '0, 32'd7140);                // lost time equals timeout
      push_frame(1'b0, '0, '0, 32'd7141);                // one past: homing, short interval
      push_frame(1'b0, '0, '0, 32'd7300);
      push_frame(1'b0, '0, '0, 32'd7000);                // timestamp goes backwards
      push_frame(1'b0, '0, '0, 32'd9000);                // long interval
      push_frame(1'b1, -16'sd20000, 16'sd20000, 32'hFFFF_FFF0);
      push_frame(1'b0, 16'h1234, 16'h4321, 32'h0000_0010);   // wrap in lost time
      push_frame(1'b0, '0, '0, 32'h0000_1000);
      for (int k = 1; k <= 8; k++)
         push_frame(1'b0, '0, '0, 32'h0000_1000 + k * 200);  // home down to zero
      stamp_ms = 32'h0000_2000;
      drain_frames();

      // Upper extremes: widest band, full gains, limits past the angle cap
      program_setup(17'h07FFF, 17'h07FFF, 17'h0FFFF, 17'h0FFFF,
                    17'h0FFFF, 17'h10000, 17'h0FFFF, 17'h0FFFF);
      track_random(PHASE_FRAMES);
      drain_frames();

      // Lower extremes: no band, zero gains, zero limits, zero timeout
      program_setup('0, '0, '0, '0, '0, '0, '0, '0);
      track_random(PHASE_FRAMES);
      drain_frames();

      // Crossed pitch limits, tight yaw limit, short timeout
      program_setup(17'd1638, 17'd1638, 17'd2560, 17'd2560,
                    17'd300, 17'd5000, CSR_DATA_W'(-5000), 17'd100);
      track_random(PHASE_FRAMES);
      drain_frames();

      for (int k = 0; k < 5; k++) begin
         random_setup(k == 0);
         track_random(PHASE_FRAMES);
         drain_frames();
      end

      // Let any straggling transfer show up before the verdict
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && cmd_q.size() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
